// ----- rtl/psrq_pkg.sv -----
// Shared types, constants and index helpers for the position sorted release queue.
// No dependencies; every other file of the block but psrq_ifs uses this package.
package psrq_pkg;

	localparam int DEPTH   = 16;
	localparam int MAX_OUT = 16;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int RUN_W   = $clog2(MAX_OUT + 1);

	localparam logic [15:0] SPAWN_COLUMN_RESET = 16'd1800;

	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_ADVANCE = 1'b1
	} op_e_t;

	typedef enum logic [1:0] {
		RES_ACCEPTED = 2'd0,
		RES_REJECTED = 2'd1,
		RES_RELEASED = 2'd2
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CHK,
		ST_RESP,
		ST_REL_RD,
		ST_REL_CHK
	} state_t;

	typedef struct packed {
		logic [7:0]  kind;
		logic [15:0] key;
		logic [15:0] row;
	} entry_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
	} mem_req_t;

	typedef struct packed {
		logic        valid;
		res_t        code;
		logic [7:0]  kind;
		logic [15:0] row;
		logic        last;
	} emit_t;

	function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] p);
		return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] p);
		return (p == '0) ? IDX_W'(DEPTH - 1) : p - 1'b1;
	endfunction

	// head plus an offset of at most DEPTH, wrapped once
	function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] p,
			input logic [CNT_W-1:0] n);
		logic [IDX_W+1:0] s;
		s = {2'b00, p} + (IDX_W + 2)'(n);
		if (s >= (IDX_W + 2)'(DEPTH)) begin
			s = s - (IDX_W + 2)'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

// ----- rtl/psrq_ifs.sv -----
// Channel interfaces: input items, result beats and the spawn column write channel.
// Depends on nothing; payload widths are fixed by the block's field list.
interface psrq_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [7:0]  kind_code;
	logic [15:0] position;
	logic [15:0] row;
	modport source(output valid, operation, kind_code, position, row, input ready);
	modport sink(input valid, operation, kind_code, position, row, output ready);
endinterface

interface psrq_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_code;
	logic [7:0]  out_kind;
	logic [15:0] out_column;
	logic [15:0] out_row;
	logic        last_of_run;
	modport source(output valid, result_code, out_kind, out_column, out_row, last_of_run,
		input ready);
	modport sink(input valid, result_code, out_kind, out_column, out_row, last_of_run,
		output ready);
endinterface

interface psrq_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] spawn_column;
	modport source(output valid, spawn_column, input ready);
	modport sink(input valid, spawn_column, output ready);
endinterface

// ----- rtl/psrq_mem.sv -----
// Entry store: one write port, one read port, registered read data.
// Depends on psrq_pkg.
module psrq_mem (
	input  logic                clk,
	input  psrq_pkg::mem_req_t  req,
	output psrq_pkg::entry_t    rd_data
);

	psrq_pkg::entry_t mem [psrq_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

// ----- rtl/psrq_out.sv -----
// Result output register and spawn column configuration register.
// Depends on psrq_pkg and psrq_ifs.
module psrq_out (
	input  logic                clk,
	input  logic                arst_n,
	input  psrq_pkg::emit_t     emit,
	output logic                out_free,
	psrq_cfg_if.sink            cfg,
	psrq_out_if.source          result
);

	logic        valid_q;
	logic [15:0] spawn_column_q;
	logic [1:0]  code_q;
	logic [7:0]  kind_q;
	logic [15:0] column_q;
	logic [15:0] row_q;
	logic        last_q;

	assign out_free  = !valid_q || result.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= 1'b0;
			spawn_column_q <= psrq_pkg::SPAWN_COLUMN_RESET;
		end else begin
			if (emit.valid) begin
				valid_q <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				spawn_column_q <= cfg.spawn_column;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			code_q   <= emit.code;
			kind_q   <= emit.kind;
			row_q    <= emit.row;
			last_q   <= emit.last;
			column_q <= (emit.code == psrq_pkg::RES_RELEASED) ? spawn_column_q : 16'd0;
		end
	end

	assign result.valid       = valid_q;
	assign result.result_code = code_q;
	assign result.out_kind    = kind_q;
	assign result.out_column  = column_q;
	assign result.out_row     = row_q;
	assign result.last_of_run = last_q;

endmodule

// ----- rtl/psrq_ctrl.sv -----
// Sequencer: insert by shifting entries up from the tail, release by popping the head.
// Depends on psrq_pkg and psrq_ifs; drives psrq_mem and psrq_out.
module psrq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	psrq_in_if.sink             item,
	output psrq_pkg::mem_req_t  mem_req,
	input  psrq_pkg::entry_t    rd_data,
	output psrq_pkg::emit_t     emit,
	input  logic                out_free
);

	psrq_pkg::state_t state_q, state_d;

	logic [psrq_pkg::IDX_W-1:0] head_q;
	logic [psrq_pkg::CNT_W-1:0] count_q;
	logic [psrq_pkg::IDX_W-1:0] wptr_q;
	logic [psrq_pkg::CNT_W-1:0] j_q;
	logic [psrq_pkg::RUN_W-1:0] n_q;
	logic                       have_pend_q;
	psrq_pkg::entry_t           new_q;
	psrq_pkg::entry_t           pend_q;
	psrq_pkg::res_t             code_q;

	logic accept, full, more, due, shift, ins_done, pop;

	assign accept = item.valid && item.ready;
	assign full   = (count_q == psrq_pkg::CNT_W'(psrq_pkg::DEPTH));
	assign more   = (count_q != '0) && (n_q < psrq_pkg::RUN_W'(psrq_pkg::MAX_OUT));
	assign due    = (rd_data.key <= new_q.key);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			psrq_pkg::ST_IDLE: begin
				if (accept) begin
					if (item.operation == psrq_pkg::OP_ADVANCE) begin
						state_d = psrq_pkg::ST_REL_RD;
					end else if (full) begin
						state_d = psrq_pkg::ST_RESP;
					end else begin
						state_d = psrq_pkg::ST_INS_RD;
					end
				end
			end
			psrq_pkg::ST_INS_RD: begin
				state_d = (j_q == '0) ? psrq_pkg::ST_RESP : psrq_pkg::ST_INS_CHK;
			end
			psrq_pkg::ST_INS_CHK: begin
				state_d = (rd_data.key > new_q.key) ? psrq_pkg::ST_INS_RD : psrq_pkg::ST_RESP;
			end
			psrq_pkg::ST_RESP: begin
				if (out_free) begin
					state_d = psrq_pkg::ST_IDLE;
				end
			end
			psrq_pkg::ST_REL_RD: begin
				if (more) begin
					state_d = psrq_pkg::ST_REL_CHK;
				end else if (!have_pend_q || out_free) begin
					state_d = psrq_pkg::ST_IDLE;
				end
			end
			psrq_pkg::ST_REL_CHK: begin
				if (!have_pend_q || out_free) begin
					state_d = due ? psrq_pkg::ST_REL_RD : psrq_pkg::ST_IDLE;
				end
			end
			default: state_d = psrq_pkg::ST_IDLE;
		endcase
	end

	// outputs and strobes
	always_comb begin
		item.ready = 1'b0;
		mem_req    = '0;
		emit       = '0;
		shift      = 1'b0;
		ins_done   = 1'b0;
		pop        = 1'b0;
		unique case (state_q)
			psrq_pkg::ST_IDLE: begin
				item.ready = 1'b1;
			end
			psrq_pkg::ST_INS_RD: begin
				if (j_q == '0) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = wptr_q;
					mem_req.wr_data = new_q;
					ins_done        = 1'b1;
				end else begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = psrq_pkg::idx_prev(wptr_q);
				end
			end
			psrq_pkg::ST_INS_CHK: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = wptr_q;
				if (rd_data.key > new_q.key) begin
					mem_req.wr_data = rd_data;
					shift           = 1'b1;
				end else begin
					mem_req.wr_data = new_q;
					ins_done        = 1'b1;
				end
			end
			psrq_pkg::ST_RESP: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.code  = code_q;
					emit.last  = 1'b1;
				end
			end
			psrq_pkg::ST_REL_RD: begin
				if (more) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = head_q;
				end else if (have_pend_q && out_free) begin
					emit.valid = 1'b1;
					emit.code  = psrq_pkg::RES_RELEASED;
					emit.kind  = pend_q.kind;
					emit.row   = pend_q.row;
					emit.last  = 1'b1;
				end
			end
			psrq_pkg::ST_REL_CHK: begin
				if (have_pend_q && out_free) begin
					emit.valid = 1'b1;
					emit.code  = psrq_pkg::RES_RELEASED;
					emit.kind  = pend_q.kind;
					emit.row   = pend_q.row;
					emit.last  = !due;
				end
				pop = due && (!have_pend_q || out_free);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= psrq_pkg::ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			wptr_q      <= '0;
			j_q         <= '0;
			n_q         <= '0;
			have_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				wptr_q      <= psrq_pkg::idx_add(head_q, count_q);
				j_q         <= count_q;
				n_q         <= '0;
				have_pend_q <= 1'b0;
			end
			if (shift) begin
				wptr_q <= psrq_pkg::idx_prev(wptr_q);
				j_q    <= j_q - 1'b1;
			end
			if (ins_done) begin
				count_q <= count_q + 1'b1;
			end
			if (pop) begin
				head_q      <= psrq_pkg::idx_next(head_q);
				count_q     <= count_q - 1'b1;
				n_q         <= n_q + 1'b1;
				have_pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			new_q.kind <= item.kind_code;
			new_q.key  <= item.position;
			new_q.row  <= item.row;
			code_q     <= full ? psrq_pkg::RES_REJECTED : psrq_pkg::RES_ACCEPTED;
		end
		if (pop) begin
			pend_q <= rd_data;
		end
	end

endmodule

// ----- rtl/position_sorted_release_queue.sv -----
// Position sorted release queue: sorted entry store with insert and advance/release.
// Depends on psrq_pkg, psrq_ifs, psrq_mem, psrq_ctrl and psrq_out.
//  item   - input beats. operation 0 inserts (kind_code, position as key, row);
//           operation 1 advances to position and releases every head entry whose
//           key is at or below it (at most 16 per advance).
//  result - output beats. An insert gives one status beat (accepted, or rejected
//           when the queue already holds 16 entries). An advance gives one beat
//           per released entry, each with the spawn column, and last_of_run on the
//           final one; an advance that releases nothing gives no beat.
//  cfg    - writes the spawn column; always ready, applies to beats loaded after the write.
// Entries sit in a ring buffer in a RAM with registered read data; each entry
// visited takes a read state, then a compare and write-back state. An insert
// shifts entries up from the tail until its place is found, then loads its status
// beat; a rejected insert goes straight to its status beat. An advance reads and
// compares head entries in turn and loads one beat per released entry. A new item
// is taken in the cycle after the last beat is loaded; one item at a time.
// Reset empties the queue (count and head cleared, RAM left as is) and sets the
// spawn column to 1800. A stalled receiver holds the sequencer once the output
// register is full; the next item is taken while the last beat waits there.
module position_sorted_release_queue (
	input  logic        clk,
	input  logic        arst_n,
	psrq_in_if.sink     item,
	psrq_out_if.source  result,
	psrq_cfg_if.sink    cfg
);

	psrq_pkg::mem_req_t mem_req;
	psrq_pkg::entry_t   rd_data;
	psrq_pkg::emit_t    emit;
	logic               out_free;

	psrq_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	psrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.mem_req  (mem_req),
		.rd_data  (rd_data),
		.emit     (emit),
		.out_free (out_free)
	);

	psrq_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.emit     (emit),
		.out_free (out_free),
		.cfg      (cfg),
		.result   (result)
	);

endmodule

// ----- tb/sv/position_sorted_release_queue_tb.sv -----
// Self-checking testbench for position_sorted_release_queue: predicts every result beat
// from its own sorted entry list and checks beats as they leave the block.
// Depends on psrq_pkg, psrq_ifs and the block's RTL.
module position_sorted_release_queue_tb;

	// No accepted beat on any channel for this many cycles means the block hung.
	localparam int HANG_LIMIT = 2000;
	// Quiet cycles before a column write; covers an advance that releases nothing.
	localparam int SETTLE_CYCLES = 2 * psrq_pkg::DEPTH + 8;

	typedef struct {
		psrq_pkg::op_e_t op;
		logic [7:0]      kind;
		logic [15:0]     position;
		logic [15:0]     row;
	} item_t;

	typedef struct {
		psrq_pkg::res_t code;
		logic [7:0]     kind;
		logic [15:0]    column;
		logic [15:0]    row;
		logic           last;
	} beat_t;

	logic clk;
	logic arst_n;

	psrq_in_if  item_if();
	psrq_out_if result_if();
	psrq_cfg_if cfg_if();

	position_sorted_release_queue u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	// Predicted queue contents, sorted by key, oldest first among equal keys.
	psrq_pkg::entry_t spawn_list[$];
	logic [15:0]      spawn_col;
	// Result beats predicted but not yet seen on the result channel.
	beat_t            release_beats_q[$];
	// Items waiting for the driver.
	item_t            item_q[$];

	int          queued_cnt;
	int          accepted_cnt;
	int          mismatches;
	int          quiet_cycles;
	int          send_idle_pct;
	int          recv_stall_pct;
	logic        item_taken;
	logic [15:0] scroll;
	logic [15:0] last_key;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one accepted item to the predicted queue and queue its result beats.
	task automatic schedule_item(input item_t it);
		int               at;
		int               n;
		psrq_pkg::entry_t e;
		beat_t            b;
		if (it.op == psrq_pkg::OP_INSERT) begin
			b = '{code: psrq_pkg::RES_ACCEPTED, kind: '0, column: '0, row: '0, last: 1'b1};
			if (spawn_list.size() >= psrq_pkg::DEPTH) begin
				// full: queue left as is, status flags the rejection
				b.code = psrq_pkg::RES_REJECTED;
			end else begin
				// goes behind every key <= its own, so ties keep arrival order
				at = 0;
				while (at < spawn_list.size() && spawn_list[at].key <= it.position) begin
					at++;
				end
				e.kind = it.kind;
				e.key  = it.position;
				e.row  = it.row;
				spawn_list.insert(at, e);
			end
			release_beats_q.push_back(b);
		end else begin
			// release due heads, at most MAX_OUT per advance; none due -> no beat
			n = 0;
			while (spawn_list.size() > 0 && n < psrq_pkg::MAX_OUT
					&& spawn_list[0].key <= it.position) begin
				b.code   = psrq_pkg::RES_RELEASED;
				b.kind   = spawn_list[0].kind;
				b.column = spawn_col;
				b.row    = spawn_list[0].row;
				b.last   = 1'b0;
				release_beats_q.push_back(b);
				void'(spawn_list.pop_front());
				n++;
			end
			if (n > 0) begin
				release_beats_q[release_beats_q.size() - 1].last = 1'b1;
			end
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Monitor: everything sampled at the rising edge. Result check comes before
	// prediction so a beat can never be matched against the item taken alongside it.
	always @(posedge clk) begin
		logic  moved;
		item_t it;
		beat_t want;
		moved = 1'b0;
		item_taken <= item_if.valid && item_if.ready;
		if (result_if.valid && result_if.ready) begin
			moved = 1'b1;
			if (release_beats_q.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual code %0d kind %0d col %0d row %0d last %0d",
					$time, result_if.result_code, result_if.out_kind,
					result_if.out_column, result_if.out_row, result_if.last_of_run);
				mismatches++;
			end else begin
				want = release_beats_q.pop_front();
				check_field("result_code", want.code, result_if.result_code);
				check_field("out_kind", want.kind, result_if.out_kind);
				check_field("out_column", want.column, result_if.out_column);
				check_field("out_row", want.row, result_if.out_row);
				check_field("last_of_run", want.last, result_if.last_of_run);
			end
		end
		if (cfg_if.valid && cfg_if.ready) begin
			moved = 1'b1;
			spawn_col = cfg_if.spawn_column;
		end
		if (item_if.valid && item_if.ready) begin
			moved = 1'b1;
			it.op       = psrq_pkg::op_e_t'(item_if.operation);
			it.kind     = item_if.kind_code;
			it.position = item_if.position;
			it.row      = item_if.row;
			schedule_item(it);
			accepted_cnt++;
		end
		quiet_cycles <= moved ? 0 : quiet_cycles + 1;
	end

	// Driver: inputs move on the falling edge. Valid holds until the beat is taken;
	// a fresh item then follows unless the sender idles this cycle.
	always @(negedge clk) begin
		item_t nxt;
		if (!item_if.valid || item_taken) begin
			if (item_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = item_q.pop_front();
				item_if.valid     <= 1'b1;
				item_if.operation <= nxt.op;
				item_if.kind_code <= nxt.kind;
				item_if.position  <= nxt.position;
				item_if.row       <= nxt.row;
			end else begin
				item_if.valid <= 1'b0;
			end
		end
		result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic queue_item(input psrq_pkg::op_e_t op, input logic [7:0] kind,
			input logic [15:0] position, input logic [15:0] row);
		item_t it;
		it.op       = op;
		it.kind     = kind;
		it.position = position;
		it.row      = row;
		item_q.push_back(it);
		queued_cnt++;
	endtask

	// Mostly a scroll position moving forward with inserts just ahead of it;
	// some keys anywhere, some repeated keys, and the odd flush to the far end.
	task automatic queue_random_items(input int n);
		logic [15:0] key;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 55) begin
				case ($urandom_range(0, 9))
					0: begin
						key = 16'($urandom);
					end
					1, 2: begin
						key = last_key;
					end
					default: begin
						key = scroll + 16'($urandom_range(0, 3000));
					end
				endcase
				last_key = key;
				queue_item(psrq_pkg::OP_INSERT, 8'($urandom), key, 16'($urandom));
			end else begin
				scroll = scroll + 16'($urandom_range(0, 2500));
				key = ($urandom_range(0, 19) == 0) ? 16'hFFFF : scroll;
				queue_item(psrq_pkg::OP_ADVANCE, 8'($urandom), key, 16'($urandom));
			end
		end
	endtask

	// Hold the sender off until every item is taken and every beat has come out,
	// then let the block settle before touching the column register.
	task automatic drain_and_settle();
		while (accepted_cnt != queued_cnt || release_beats_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_spawn_column(input logic [15:0] value);
		@(negedge clk);
		cfg_if.valid        <= 1'b1;
		cfg_if.spawn_column <= value;
		@(posedge clk);
		while (!cfg_if.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Hang watchdog.
	initial begin
		quiet_cycles = 0;
		@(posedge arst_n);
		while (quiet_cycles < HANG_LIMIT) begin
			@(posedge clk);
		end
		$display("%0t: no beat accepted for %0d cycles", $time, HANG_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		clk                 = 1'b0;
		arst_n              = 1'b0;
		item_if.valid       = 1'b0;
		item_if.operation   = psrq_pkg::OP_INSERT;
		item_if.kind_code   = '0;
		item_if.position    = '0;
		item_if.row         = '0;
		result_if.ready     = 1'b0;
		cfg_if.valid        = 1'b0;
		cfg_if.spawn_column = '0;
		item_taken          = 1'b0;
		queued_cnt          = 0;
		accepted_cnt        = 0;
		mismatches          = 0;
		send_idle_pct       = 0;
		recv_stall_pct      = 0;
		spawn_col           = psrq_pkg::SPAWN_COLUMN_RESET;
		scroll              = '0;
		last_key            = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, column at its reset value.
		// advance on an empty queue: nothing due
		queue_item(psrq_pkg::OP_ADVANCE, 8'hFF, 16'hFFFF, 16'hFFFF);
		// field extremes and three equal keys that must leave in arrival order
		queue_item(psrq_pkg::OP_INSERT, 8'hFF, 16'hFFFF, 16'hFFFF);
		queue_item(psrq_pkg::OP_INSERT, 8'h00, 16'h0000, 16'h0000);
		queue_item(psrq_pkg::OP_INSERT, 8'd1, 16'd100, 16'd10);
		queue_item(psrq_pkg::OP_INSERT, 8'd2, 16'd100, 16'd20);
		queue_item(psrq_pkg::OP_INSERT, 8'd3, 16'd100, 16'd30);
		// fill to DEPTH with keys between the extremes
		for (int i = 0; i < psrq_pkg::DEPTH - 5; i++) begin
			queue_item(psrq_pkg::OP_INSERT, 8'($urandom), 16'($urandom_range(200, 60000)),
				16'($urandom));
		end
		// queue full: rejected
		queue_item(psrq_pkg::OP_INSERT, 8'hAA, 16'h0000, 16'h5555);
		// releases the key-0 entry only
		queue_item(psrq_pkg::OP_ADVANCE, 8'h00, 16'd99, 16'h0000);
		// head key 100 is above the position: nothing due
		queue_item(psrq_pkg::OP_ADVANCE, 8'h55, 16'd99, 16'hAAAA);
		// refill, then one advance releases a full DEPTH-long run
		queue_item(psrq_pkg::OP_INSERT, 8'h5A, 16'd150, 16'hA5A5);
		queue_item(psrq_pkg::OP_ADVANCE, 8'h00, 16'hFFFF, 16'h0000);
		drain_and_settle();

		// Random phases, column changed between them while the block is idle.
		write_spawn_column(16'hFFFF);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		queue_random_items(25);
		drain_and_settle();

		write_spawn_column(16'h0000);
		send_idle_pct  = 49;
		recv_stall_pct = 0;
		queue_random_items(25);
		drain_and_settle();

		write_spawn_column(16'($urandom));
		send_idle_pct  = 0;
		recv_stall_pct = 49;
		queue_random_items(25);
		drain_and_settle();

		write_spawn_column(16'($urandom));
		send_idle_pct  = 36;
		recv_stall_pct = 36;
		queue_random_items(25);
		drain_and_settle();

		if (release_beats_q.size() != 0) begin
			$display("%0t: %0d expected beats never arrived", $time, release_beats_q.size());
		end
		if (mismatches == 0 && release_beats_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
